// ----- rtl/rfa_pkg.sv -----
// Shared types for the rational fraction ALU: words, commands and controller/datapath links.
package rfa_pkg;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_SUB    = 3'd1,
    CMD_MUL    = 3'd2,
    CMD_DIV    = 3'd3,
    CMD_REDUCE = 3'd4,
    CMD_INVERT = 3'd5
  } cmd_code_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] first_numerator;
    logic signed [31:0] first_denominator;
    logic signed [31:0] second_numerator;
    logic signed [31:0] second_denominator;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_numerator;
    logic signed [31:0] result_denominator;
  } out_word_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_MUL_START,
    DP_MUL_TO_RN,
    DP_MUL_ADD_RN,
    DP_MUL_SUB_RN,
    DP_MUL_TO_RD,
    DP_COPY,
    DP_INVERT,
    DP_GCD_INIT,
    DP_REM_START,
    DP_REM_WB,
    DP_NUM_START,
    DP_NUM_WB,
    DP_DEN_START,
    DP_DEN_WB,
    DP_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    MS_AN_BD,
    MS_BN_AD,
    MS_AD_BD,
    MS_AN_BN,
    MS_AD_BN
  } mul_sel_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t mul_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic gb_zero;
  } dp_sts_t;

endpackage

// ----- rtl/rfa_ctrl.sv -----
// Controller state machine for the rational fraction ALU.
module rfa_ctrl
  import rfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [2:0] in_command,
  output logic      out_valid,
  input  logic      out_ready,
  output dp_cmd_t   dp_cmd,
  input  dp_sts_t   dp_sts
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD,
    S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M3W,
    S_COPY, S_INV, S_GINIT, S_GTEST, S_RSTART, S_RWAIT,
    S_NSTART, S_NWAIT, S_DSTART, S_DWAIT, S_OUT, S_PASS
  } state_t;

  state_t          state_r, state_nxt;
  logic [2:0]      cmd_r, cmd_nxt;
  logic            out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    dp_cmd.op      = DP_NONE;
    dp_cmd.mul_sel = MS_AN_BD;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.op = DP_LOAD;
          cmd_nxt   = in_command;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        priority if (cmd_r == CMD_ADD || cmd_r == CMD_SUB || cmd_r == CMD_MUL ||
                     cmd_r == CMD_DIV) begin
          state_nxt = S_M1;
        end else if (cmd_r == CMD_REDUCE) begin
          state_nxt = S_COPY;
        end else if (cmd_r == CMD_INVERT) begin
          state_nxt = S_INV;
        end else begin
          state_nxt = S_PASS;
        end
      end
      S_M1: begin
        dp_cmd.op      = DP_MUL_START;
        dp_cmd.mul_sel = (cmd_r == CMD_MUL) ? MS_AN_BN : MS_AN_BD;
        state_nxt      = S_M1W;
      end
      S_M1W: begin
        if (!dp_sts.mul_busy) begin
          dp_cmd.op = DP_MUL_TO_RN;
          state_nxt = (cmd_r == CMD_ADD || cmd_r == CMD_SUB) ? S_M2 : S_M3;
        end
      end
      S_M2: begin
        dp_cmd.op      = DP_MUL_START;
        dp_cmd.mul_sel = MS_BN_AD;
        state_nxt      = S_M2W;
      end
      S_M2W: begin
        if (!dp_sts.mul_busy) begin
          dp_cmd.op = (cmd_r == CMD_SUB) ? DP_MUL_SUB_RN : DP_MUL_ADD_RN;
          state_nxt = S_M3;
        end
      end
      S_M3: begin
        dp_cmd.op      = DP_MUL_START;
        dp_cmd.mul_sel = (cmd_r == CMD_DIV) ? MS_AD_BN : MS_AD_BD;
        state_nxt      = S_M3W;
      end
      S_M3W: begin
        if (!dp_sts.mul_busy) begin
          dp_cmd.op = DP_MUL_TO_RD;
          state_nxt = S_GINIT;
        end
      end
      S_COPY: begin
        dp_cmd.op = DP_COPY;
        state_nxt = S_GINIT;
      end
      S_PASS: begin
        dp_cmd.op = DP_COPY;
        state_nxt = S_OUT;
      end
      S_INV: begin
        dp_cmd.op = DP_INVERT;
        state_nxt = S_OUT;
      end
      S_GINIT: begin
        dp_cmd.op = DP_GCD_INIT;
        state_nxt = S_GTEST;
      end
      S_GTEST: begin
        state_nxt = dp_sts.gb_zero ? S_NSTART : S_RSTART;
      end
      S_RSTART: begin
        dp_cmd.op = DP_REM_START;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        if (!dp_sts.div_busy) begin
          dp_cmd.op = DP_REM_WB;
          state_nxt = S_GTEST;
        end
      end
      S_NSTART: begin
        dp_cmd.op = DP_NUM_START;
        state_nxt = S_NWAIT;
      end
      S_NWAIT: begin
        if (!dp_sts.div_busy) begin
          dp_cmd.op = DP_NUM_WB;
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: begin
        dp_cmd.op = DP_DEN_START;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (!dp_sts.div_busy) begin
          dp_cmd.op = DP_DEN_WB;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          dp_cmd.op     = DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_sts.mul_busy && dp_sts.div_busy))
    else $error("multiplier and divider busy together");
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before taken");
  a_load_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (dp_cmd.op == DP_LOAD))
    else $error("accepted word not loaded");
`endif

endmodule

// ----- rtl/rfa_dpath.sv -----
// Datapath: operand registers, shift-add multiplier and restoring divider.
module rfa_dpath
  import rfa_pkg::*;
#(
  parameter int W = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_data,
  output out_word_t out_data,
  input  dp_cmd_t   dp_cmd,
  output dp_sts_t   dp_sts
);

  localparam int CW = $clog2(W + 1);

  logic signed [W-1:0] an_r, ad_r, bn_r, bd_r, rn_r, rd_r, ga_r, gb_r;
  logic signed [W-1:0] an_w, ad_w, bn_w, bd_w, g_fix;
  logic [W-1:0]        ma_r, mb_r, macc_r;
  logic [CW-1:0]       mcnt_r;
  logic                mbusy_r;
  logic [W-1:0]        dq_r, drem_r, dvs_r;
  logic                dnq_r, dnr_r, dbusy_r;
  logic [CW-1:0]       dcnt_r;
  logic signed [W-1:0] dvd_sel, dvs_sel, quot, remv, msel_a, msel_b;
  logic [W:0]          dtmp, ddiff;
  logic signed [63:0]  on_ext, od_ext;
  out_word_t           out_r;

  assign an_w = W'(64'(in_data.first_numerator));
  assign ad_w = W'(64'(in_data.first_denominator));
  assign bn_w = W'(64'(in_data.second_numerator));
  assign bd_w = W'(64'(in_data.second_denominator));
  assign g_fix = (ga_r > 0) ? ga_r : W'(1);

  assign dp_sts.mul_busy = mbusy_r;
  assign dp_sts.div_busy = dbusy_r;
  assign dp_sts.gb_zero  = (gb_r == '0);

  always_comb begin
    unique case (dp_cmd.mul_sel)
      MS_AN_BD: begin msel_a = an_r; msel_b = bd_r; end
      MS_BN_AD: begin msel_a = bn_r; msel_b = ad_r; end
      MS_AD_BD: begin msel_a = ad_r; msel_b = bd_r; end
      MS_AN_BN: begin msel_a = an_r; msel_b = bn_r; end
      MS_AD_BN: begin msel_a = ad_r; msel_b = bn_r; end
      default:  begin msel_a = an_r; msel_b = bd_r; end
    endcase
    unique case (dp_cmd.op)
      DP_REM_START: begin dvd_sel = ga_r; dvs_sel = gb_r;  end
      DP_NUM_START: begin dvd_sel = rn_r; dvs_sel = g_fix; end
      default:      begin dvd_sel = rd_r; dvs_sel = g_fix; end
    endcase
  end

  assign dtmp  = {drem_r, dq_r[W-1]};
  assign ddiff = dtmp - {1'b0, dvs_r};
  assign quot  = dnq_r ? -dq_r : dq_r;
  assign remv  = dnr_r ? -drem_r : drem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      dbusy_r <= 1'b0;
    end else begin
      if (dp_cmd.op == DP_MUL_START) begin
        mbusy_r <= 1'b1;
      end else if (mbusy_r && mcnt_r == CW'(1)) begin
        mbusy_r <= 1'b0;
      end
      if (dp_cmd.op == DP_REM_START || dp_cmd.op == DP_NUM_START ||
          dp_cmd.op == DP_DEN_START) begin
        dbusy_r <= 1'b1;
      end else if (dbusy_r && dcnt_r == CW'(1)) begin
        dbusy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.op == DP_MUL_START) begin
      ma_r   <= msel_a;
      mb_r   <= msel_b;
      macc_r <= '0;
      mcnt_r <= CW'(W);
    end else if (mbusy_r) begin
      macc_r <= macc_r + (mb_r[0] ? ma_r : '0);
      ma_r   <= ma_r << 1;
      mb_r   <= mb_r >> 1;
      mcnt_r <= mcnt_r - CW'(1);
    end
    if (dp_cmd.op == DP_REM_START || dp_cmd.op == DP_NUM_START ||
        dp_cmd.op == DP_DEN_START) begin
      dq_r   <= dvd_sel[W-1] ? -dvd_sel : dvd_sel;
      dvs_r  <= dvs_sel[W-1] ? -dvs_sel : dvs_sel;
      dnq_r  <= dvd_sel[W-1] ^ dvs_sel[W-1];
      dnr_r  <= dvd_sel[W-1];
      drem_r <= '0;
      dcnt_r <= CW'(W);
    end else if (dbusy_r) begin
      if (!ddiff[W]) begin
        drem_r <= ddiff[W-1:0];
        dq_r   <= {dq_r[W-2:0], 1'b1};
      end else begin
        drem_r <= dtmp[W-1:0];
        dq_r   <= {dq_r[W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - CW'(1);
    end
    unique case (dp_cmd.op)
      DP_LOAD: begin
        an_r <= an_w;
        ad_r <= (ad_w == '0) ? W'(1) : ad_w;
        bn_r <= bn_w;
        bd_r <= (bd_w == '0) ? W'(1) : bd_w;
      end
      DP_MUL_TO_RN:  rn_r <= macc_r;
      DP_MUL_ADD_RN: rn_r <= rn_r + macc_r;
      DP_MUL_SUB_RN: rn_r <= rn_r - macc_r;
      DP_MUL_TO_RD:  rd_r <= macc_r;
      DP_COPY: begin
        rn_r <= an_r;
        rd_r <= ad_r;
      end
      DP_INVERT: begin
        rn_r <= ad_r;
        rd_r <= (an_r == '0) ? W'(1) : an_r;
      end
      DP_GCD_INIT: begin
        ga_r <= rn_r;
        gb_r <= rd_r;
      end
      DP_REM_WB: begin
        ga_r <= gb_r;
        gb_r <= remv;
      end
      DP_NUM_WB: rn_r <= quot;
      DP_DEN_WB: rd_r <= (quot == '0) ? W'(1) : quot;
      DP_OUT: begin
        out_r.result_numerator   <= on_ext[31:0];
        out_r.result_denominator <= od_ext[31:0];
      end
      default: ;
    endcase
  end

  assign on_ext   = 64'(rn_r);
  assign od_ext   = 64'(rd_r);
  assign out_data = out_r;

endmodule

// ----- rtl/rational_fraction_alu.sv -----
// Top level of the rational fraction ALU.
// Takes one command word (add, subtract, multiply, divide, reduce or invert on
// two signed fractions) and returns one fraction, reduced unless the command
// is invert; codes 6 and 7 pass the first fraction through. Products wrap at
// WORD_WIDTH bits and come from a shift-add multiplier, up to three per word.
// Reduction runs Euclid's algorithm on a shared restoring divider, one
// division per remainder step, then two more divisions for the final parts.
// One word is in work at a time; a finished result waits in an output
// register while the next word enters.
module rational_fraction_alu
  import rfa_pkg::*;
#(
  parameter int WORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  rfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .dp_cmd     (dp_cmd),
    .dp_sts     (dp_sts)
  );

  rfa_dpath #(.W(WORD_WIDTH)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .dp_cmd   (dp_cmd),
    .dp_sts   (dp_sts)
  );

endmodule

// ----- tb/sv/rational_fraction_alu_checker.sv -----
// Checker for the rational fraction ALU: predicts each result word and compares it.
`timescale 1ns / 100ps
module rational_fraction_alu_checker
  import rfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending_count
);

  out_word_t fractions_due[$];

  function automatic logic signed [31:0] trunc_mod(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    if (b == -32'sd1) return 32'sd0;
    return a % b;
  endfunction

  function automatic out_word_t lowest_terms(logic signed [31:0] num,
                                             logic signed [31:0] den);
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] r;
    out_word_t res;
    x = num;
    y = den;
    while (y != 0) begin
      r = trunc_mod(x, y);
      x = y;
      y = r;
    end
    if (x < 1) x = 1;
    res.result_numerator = (x == 1) ? num : num / x;
    res.result_denominator = (x == 1) ? den : den / x;
    if (res.result_denominator == 0) res.result_denominator = 1;
    return res;
  endfunction

  function automatic out_word_t fraction_result(in_word_t w);
    logic signed [31:0] an;
    logic signed [31:0] ad;
    logic signed [31:0] bn;
    logic signed [31:0] bd;
    out_word_t res;
    an = w.first_numerator;
    ad = (w.first_denominator == 0) ? 32'sd1 : w.first_denominator;
    bn = w.second_numerator;
    bd = (w.second_denominator == 0) ? 32'sd1 : w.second_denominator;
    case (w.command)
      CMD_ADD:    res = lowest_terms(an * bd + bn * ad, ad * bd);
      CMD_SUB:    res = lowest_terms(an * bd - bn * ad, ad * bd);
      CMD_MUL:    res = lowest_terms(an * bn, ad * bd);
      CMD_DIV:    res = lowest_terms(an * bd, ad * bn);
      CMD_REDUCE: res = lowest_terms(an, ad);
      CMD_INVERT: begin
        res.result_numerator = ad;
        res.result_denominator = (an == 0) ? 32'sd1 : an;
      end
      default: begin
        res.result_numerator = an;
        res.result_denominator = ad;
      end
    endcase
    return res;
  endfunction

  assign pending_count = fractions_due.size();

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) fractions_due.push_back(fraction_result(in_data));
      if (out_valid && out_ready) begin
        if (fractions_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = fractions_due.pop_front();
          if (want.result_numerator !== out_data.result_numerator ||
              want.result_denominator !== out_data.result_denominator) begin
            if (fail_count < 10)
              $display("mismatch: expected %0d/%0d, got %0d/%0d",
                       want.result_numerator, want.result_denominator,
                       out_data.result_numerator, out_data.result_denominator);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/rational_fraction_alu_tb.sv -----
// Testbench top for the rational fraction ALU: drives command words and gives the verdict.
`timescale 1ns / 100ps
module rational_fraction_alu_tb;
  import rfa_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  int        fail_count;
  int        pending_count;
  int        send_idle_pct = 18;
  int        recv_idle_pct = 55;
  int        cycle_count = 0;

  localparam int CYCLE_LIMIT = 3000000;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rational_fraction_alu i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  rational_fraction_alu_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_part();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(40)) - 20;
      2: return $signed($urandom_range(2000)) - 1000;
      3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(200000)) - 100000;
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.command = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                          : 3'($urandom_range(5));
    w.first_numerator = pick_part();
    w.first_denominator = pick_part();
    w.second_numerator = pick_part();
    w.second_denominator = pick_part();
    return w;
  endfunction

  task automatic send_fraction(logic [2:0] c, int an, int ad, int bn, int bd);
    in_word_t w;
    w.command = c;
    w.first_numerator = an;
    w.first_denominator = ad;
    w.second_numerator = bn;
    w.second_denominator = bd;
    send_word(w);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_fraction(CMD_ADD, 1, 2, 1, 3);
    send_fraction(CMD_SUB, 3, 4, 1, 4);
    send_fraction(CMD_MUL, -6, 4, 2, -9);
    send_fraction(CMD_DIV, 5, 7, 10, 21);
    send_fraction(CMD_REDUCE, 12, 18, 0, 0);
    send_fraction(CMD_REDUCE, -12, 18, 0, 0);
    send_fraction(CMD_REDUCE, 12, -18, 0, 0);
    send_fraction(CMD_INVERT, 3, 8, 0, 0);
    send_fraction(CMD_INVERT, 0, 0, 0, 0);
    send_fraction(CMD_ADD, 1, 0, 1, 0);
    send_fraction(CMD_REDUCE, 0, 0, 0, 0);
    send_fraction(CMD_REDUCE, 32'sh80000000, -1, 0, 0);
    send_fraction(CMD_REDUCE, 7, -1, 0, 0);
    send_fraction(CMD_MUL, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 2);
    send_fraction(CMD_ADD, 32'sh80000000, 32'sh80000000, 32'sh80000000, -1);
    send_fraction(CMD_DIV, -1, -1, 32'sh80000000, 32'sh7fffffff);
    send_fraction(3'd6, 5, 0, 1, 1);
    send_fraction(3'd7, -5, 9, 1, 1);
    send_fraction(CMD_SUB, -1, -1, -1, -1);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 55 : 0;
      recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 18 : 0;
      for (int k = 0; k < 110; k++) begin
        if (k == 50) begin
          in_valid <= 1'b0;
          wait (pending_count == 0);
        end
        send_word(random_word());
      end
    end
    in_valid <= 1'b0;
    wait (pending_count == 0);
    repeat (2000) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rfa_pkg.sv
rtl/rfa_ctrl.sv
rtl/rfa_dpath.sv
rtl/rational_fraction_alu.sv
tb/sv/rational_fraction_alu_checker.sv
tb/sv/rational_fraction_alu_tb.sv
